// ===== design/tffd_pkg.sv =====
// ----------------------------------------------------------------------------
// tffd_pkg
// Shared types, constants and helpers for the trace formatter frame deframer.
// ----------------------------------------------------------------------------
package tffd_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int PAIRS       = FRAME_BYTES / 2;
    localparam int PAIR_W      = $clog2(PAIRS);
    localparam int SLOT_W      = $clog2(FRAME_BYTES);
    localparam int ADDR_W      = 3;

    localparam logic [31:0] SYNC_WORD = 32'hFFFF_FF7F;
    localparam logic [7:0]  HALF_HIGH = 8'h7F;
    localparam logic [7:0]  HALF_LOW  = 8'hFF;

    localparam logic       REG_STREAM_FILTER   = 1'b0;
    localparam logic [7:0] STREAM_FILTER_RESET = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UNPACK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic take_input;
        logic step;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic step_go;
        logic slot_end;
        logic flush_done;
    } dp_status_t;

    function automatic logic stream_pass(input logic [7:0] filter, input logic [6:0] sid);
        return (sid != 7'd0) && (filter[7] || (filter == {1'b0, sid}));
    endfunction

endpackage

// ===== design/tffd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tffd_ctrl
// Sequencer: takes bytes, walks the frame slots, flushes the final word.
// ----------------------------------------------------------------------------
module tffd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  tffd_pkg::dp_status_t status,
    output tffd_pkg::dp_cmd_t    cmd
);
    import tffd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_input = 1'b1;
                if (status.frame_done)
                begin
                    state_next = ST_UNPACK;
                end
            end
            ST_UNPACK:
            begin
                cmd.step = 1'b1;
                if (status.step_go && status.slot_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (status.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tffd_dp.sv =====
// ----------------------------------------------------------------------------
// tffd_dp
// Datapath: sync window, pair store, frame unpacking and output register.
// ----------------------------------------------------------------------------
module tffd_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tffd_pkg::dp_cmd_t    cmd,
    output tffd_pkg::dp_status_t status,
    input  logic [7:0]          stream_filter,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic [6:0]          stream_id,
    output logic                last
);
    import tffd_pkg::*;

    // control state
    logic [31:0]       window_reg, window_next;
    logic              synced_reg, synced_next;
    logic              half_reg, half_next;
    logic [PAIR_W-1:0] fill_reg, fill_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [6:0]        cur_reg, cur_next;
    logic              pend_reg, pend_next;
    logic              held_v_reg, held_v_next;
    logic              out_v_reg, out_v_next;

    // payload
    logic [7:0]        first_reg;
    logic [7:0]        flags_reg;
    logic [6:0]        next_sid_reg;
    logic [7:0]        held_byte_reg;
    logic [6:0]        held_sid_reg;
    logic [7:0]        out_byte_reg;
    logic [6:0]        out_sid_reg;
    logic              out_last_reg;
    logic [7:0]        pair_a_reg [PAIRS];
    logic [7:0]        pair_b_reg [PAIRS];

    logic              in_fire;
    logic              is_sync;
    logic              is_filler;
    logic              pair_store;
    logic              shift_en;
    logic              out_free;
    logic [PAIR_W-1:0] k;
    logic              sub;
    logic              f;
    logic              cand_v;
    logic [7:0]        cand_byte;
    logic              step_go;
    logic              push;
    logic [7:0]        push_byte;
    logic [6:0]        push_sid;
    logic              push_last;
    logic              load_held;

    assign in_fire   = cmd.take_input && in_valid;
    assign is_sync   = ({window_reg[23:0], in_byte} == SYNC_WORD);
    assign is_filler = (in_byte == HALF_HIGH) && (first_reg == HALF_LOW);
    assign out_free  = !out_v_reg || out_ready;
    assign k         = slot_reg[SLOT_W-1:1];
    assign sub       = slot_reg[0];
    assign f         = flags_reg[k];

    assign pair_store = in_fire && !is_sync && synced_reg && half_reg && !is_filler;

    // candidate word for the current slot
    always_comb
    begin
        if (!sub)
        begin
            cand_v    = !pair_a_reg[0][0] && stream_pass(stream_filter, cur_reg);
            cand_byte = {pair_a_reg[0][7:1], f};
        end
        else
        begin
            cand_v    = (k != PAIR_W'(PAIRS - 1)) && stream_pass(stream_filter, cur_reg);
            cand_byte = pair_b_reg[0];
        end
    end

    assign step_go  = cmd.step && (!(cand_v && held_v_reg) || out_free);
    assign shift_en = pair_store || (step_go && sub);

    always_comb
    begin
        window_next = window_reg;
        synced_next = synced_reg;
        half_next   = half_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        cur_next    = cur_reg;
        pend_next   = pend_reg;
        held_v_next = held_v_reg;
        push        = 1'b0;
        push_byte   = held_byte_reg;
        push_sid    = held_sid_reg;
        push_last   = 1'b0;
        load_held   = 1'b0;
        status      = '0;

        if (in_fire)
        begin
            window_next = {window_reg[23:0], in_byte};
            if (is_sync)
            begin
                synced_next = 1'b1;
                half_next   = 1'b0;
                fill_next   = '0;
            end
            else if (synced_reg)
            begin
                half_next = !half_reg;
                if (pair_store)
                begin
                    if (fill_reg == PAIR_W'(PAIRS - 1))
                    begin
                        fill_next         = '0;
                        slot_next         = '0;
                        status.frame_done = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
        end

        if (step_go)
        begin
            slot_next = slot_reg + 1'b1;
            if (cand_v)
            begin
                load_held   = 1'b1;
                held_v_next = 1'b1;
                push        = held_v_reg;
            end
            if (!sub)
            begin
                if (pair_a_reg[0][0])
                begin
                    if (f)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        cur_next = pair_a_reg[0][7:1];
                    end
                end
            end
            else if (pend_reg)
            begin
                cur_next  = next_sid_reg;
                pend_next = 1'b0;
            end
        end

        if (cmd.flush)
        begin
            if (!held_v_reg)
            begin
                status.flush_done = 1'b1;
            end
            else if (out_free)
            begin
                push              = 1'b1;
                push_last         = 1'b1;
                held_v_next       = 1'b0;
                status.flush_done = 1'b1;
            end
        end

        status.step_go  = step_go;
        status.slot_end = (slot_reg == SLOT_W'(FRAME_BYTES - 1));

        if (push)
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            synced_reg <= 1'b0;
            half_reg   <= 1'b0;
            fill_reg   <= '0;
            slot_reg   <= '0;
            cur_reg    <= '0;
            pend_reg   <= 1'b0;
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            synced_reg <= synced_next;
            half_reg   <= half_next;
            fill_reg   <= fill_next;
            slot_reg   <= slot_next;
            cur_reg    <= cur_next;
            pend_reg   <= pend_next;
            held_v_reg <= held_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && synced_reg && !half_reg)
        begin
            first_reg <= in_byte;
        end
        if (status.frame_done)
        begin
            flags_reg <= in_byte;
        end
        if (step_go && !sub && pair_a_reg[0][0] && f)
        begin
            next_sid_reg <= pair_a_reg[0][7:1];
        end
        if (load_held)
        begin
            held_byte_reg <= cand_byte;
            held_sid_reg  <= cur_reg;
        end
        if (push)
        begin
            out_byte_reg <= push_byte;
            out_sid_reg  <= push_sid;
            out_last_reg <= push_last;
        end
        if (shift_en)
        begin
            for (int i = 0; i < PAIRS - 1; i++)
            begin
                pair_a_reg[i] <= pair_a_reg[i + 1];
                pair_b_reg[i] <= pair_b_reg[i + 1];
            end
            if (pair_store)
            begin
                pair_a_reg[PAIRS - 1] <= first_reg;
                pair_b_reg[PAIRS - 1] <= in_byte;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign out_byte  = out_byte_reg;
    assign stream_id = out_sid_reg;
    assign last      = out_last_reg;

endmodule

// ===== design/trace_formatter_frame_deframer_top.sv =====
// Trace formatter frame deframer. Takes one trace-port byte per cycle while
// in_ready is high; bytes are ignored until the sync word FF FF FF 7F is seen.
// The byte that completes a 16-byte formatter frame starts the unpack
// sequencer, which walks the frame's 16 slots one per cycle (longer only when
// the output register is stalled) and then flushes the frame's final word,
// so in_ready stays low after each completed frame until that flush is done;
// other bytes never drop in_ready. Words are delivered in frame order with
// last set on the final word of each frame that yields any words.
// ----------------------------------------------------------------------------
// trace_formatter_frame_deframer_top
// Top level: APB stream filter register, sequencer and datapath.
// ----------------------------------------------------------------------------
module trace_formatter_frame_deframer_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tffd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic [6:0]                stream_id,
    output logic                      last
);
    import tffd_pkg::*;

    logic [7:0] filter_reg;
    logic [7:0] filter_next;
    dp_cmd_t    cmd;
    dp_status_t status;

    always_comb
    begin
        filter_next = filter_reg;
        if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_STREAM_FILTER))
        begin
            filter_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= STREAM_FILTER_RESET;
        end
        else
        begin
            filter_reg <= filter_next;
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr[ADDR_W-1] == REG_STREAM_FILTER) ? {24'd0, filter_reg} : 32'd0;
    assign in_ready = cmd.take_input;

    tffd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tffd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .stream_filter (filter_reg),
        .in_valid      (in_valid),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .stream_id     (stream_id),
        .last          (last)
    );

endmodule

// ===== design/tffd_checker.sv =====
// ----------------------------------------------------------------------------
// tffd_checker
// Port-level checks on the deframer output sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module tffd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [6:0] stream_id,
    input logic       last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(stream_id)
            && $stable(last))
        else $error("stalled output word changed");

    // stream 0 never emitted
    a_sid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stream_id != 7'd0)
        else $error("word emitted on stream 0");

    // while taking bytes, only a frame's final word may wait
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("input taken while frame still unpacking");

    // a non-final word is followed by more unpacking or the frame's final word
    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready || (out_valid && last))
        else $error("input taken before frame's final word");

endmodule

bind trace_formatter_frame_deframer_top tffd_checker u_tffd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .stream_id (stream_id),
    .last      (last)
);

// ===== bench/tb_trace_formatter_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trace_formatter_frame_deframer_top
// Drives trace-port bytes through the frame deframer and checks every word.
// A scoreboard tracks sync, pair gathering, filler removal and frame
// unpacking, and compares each output word against its own prediction.
// Runs several stream filter settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_trace_formatter_frame_deframer_top;

    import tffd_pkg::*;

    localparam int          PAIR_LIMIT   = FRAME_BYTES - 2;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LONG_HOLD    = 400;
    localparam logic [ADDR_W-1:0] FILTER_ADDR = ADDR_W'(4 * int'(REG_STREAM_FILTER));
    // stream change to 0x21, data, delayed change to 5, stream 0, stream 127,
    // data, flagged data, delayed change to 6 left over at frame end
    localparam logic [127:0] DEMO_FRAME = 128'h4300_FEFF_0B80_015A_FF01_007F_02A5_0DC6;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] sid;
        logic       last;
    } word_t;

    class deframe_scoreboard;
        logic signed [7:0] filter;
        logic [31:0]       window;
        bit                synced;
        logic [7:0]        frame [FRAME_BYTES];
        int unsigned       fill;
        bit                half_pair;
        logic [6:0]        active_sid;
        word_t             pending_words [$];
        int unsigned       mismatches;
        int unsigned       frames_done;
        int unsigned       words_checked;

        function new();
            filter        = -8'sd1;
            window        = '0;
            synced        = 1'b0;
            fill          = 0;
            half_pair     = 1'b0;
            active_sid    = '0;
            mismatches    = 0;
            frames_done   = 0;
            words_checked = 0;
            foreach (frame[i])
                frame[i] = '0;
        endfunction

        function bit sid_passes(logic [6:0] sid);
            return sid != 7'd0 && (filter < 0 || {1'b0, sid} == filter);
        endfunction

        function void unpack_frame();
            word_t      fresh [$];
            word_t      w;
            logic [7:0] flags;
            logic [7:0] e;
            logic [6:0] cur;
            logic [6:0] next_sid;
            bit         f;
            bit         pend;
            int         i;
            flags = frame[FRAME_BYTES-1];
            cur   = active_sid;
            for (i = 0; i < FRAME_BYTES; i += 2)
            begin
                e        = frame[i];
                f        = flags[i/2];
                pend     = 1'b0;
                next_sid = '0;
                if (e[0])
                begin
                    if (f)
                    begin
                        pend     = 1'b1;
                        next_sid = e[7:1];
                    end
                    else
                        cur = e[7:1];
                end
                else if (sid_passes(cur))
                begin
                    w = '{data: {e[7:1], f}, sid: cur, last: 1'b0};
                    fresh = {fresh, w};
                end
                if (i < PAIR_LIMIT && sid_passes(cur))
                begin
                    w = '{data: frame[i+1], sid: cur, last: 1'b0};
                    fresh = {fresh, w};
                end
                if (pend)
                    cur = next_sid;
            end
            active_sid = cur;
            for (i = 0; i < fresh.size(); i++)
            begin
                w      = fresh[i];
                w.last = (i == fresh.size() - 1);
                pending_words = {pending_words, w};
            end
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned slot;
            window = {window[23:0], b};
            if (window == SYNC_WORD)
            begin
                synced    = 1'b1;
                fill      = 0;
                half_pair = 1'b0;
                return;
            end
            if (!synced)
                return;
            slot = fill;
            if (!half_pair)
            begin
                half_pair   = 1'b1;
                frame[slot] = b;
                return;
            end
            half_pair = 1'b0;
            if (b == HALF_HIGH && frame[slot] == HALF_LOW)
                return;
            frame[slot+1] = b;
            if (slot + 2 >= FRAME_BYTES)
            begin
                fill = 0;
                frames_done++;
                unpack_frame();
            end
            else
                fill = slot + 2;
        endfunction

        function void check_word(logic [7:0] data, logic [6:0] sid, logic lst);
            word_t w;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: out_byte=%h stream_id=%h last=%b",
                         $time, data, sid, lst);
                mismatches++;
                return;
            end
            w = pending_words.pop_front();
            words_checked++;
            if (data !== w.data)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, w.data, data);
                mismatches++;
            end
            if (sid !== w.sid)
            begin
                $display("%0t: stream_id expected %h actual %h", $time, w.sid, sid);
                mismatches++;
            end
            if (lst !== w.last)
            begin
                $display("%0t: last expected %b actual %b", $time, w.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        in_byte;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        out_byte;
    logic [6:0]        stream_id;
    logic              last;

    deframe_scoreboard sb;
    int unsigned       items_sent;
    int unsigned       tx_idle_pct;
    int unsigned       rx_stall_pct;
    int unsigned       filter_settings;
    bit                long_hold_done;

    trace_formatter_frame_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .stream_id (stream_id),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 25;
            default: return 60;
        endcase
    endfunction

    function automatic logic [6:0] pick_stream(logic signed [7:0] filt);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30 && filt > 0)
            return filt[6:0];
        if (r < 40)
            return 7'd0;
        if (r < 50)
            return 7'd127;
        if (r < 60)
            return 7'd1;
        return 7'($urandom_range(1, 127));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (items_sent % 40 == 0)
            tx_idle_pct = pick_pct();
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        items_sent++;
    endtask

    task automatic send_sync();
        send_byte(SYNC_WORD[31:24]);
        send_byte(SYNC_WORD[23:16]);
        send_byte(SYNC_WORD[15:8]);
        send_byte(SYNC_WORD[7:0]);
    endtask

    task automatic send_filler();
        send_byte(HALF_LOW);
        send_byte(HALF_HIGH);
    endtask

    // random frame content, cut short after keep bytes
    task automatic send_frame(input logic signed [7:0] filt, input int unsigned keep);
        logic [7:0] fr [FRAME_BYTES];
        int         i;
        for (i = 0; i < FRAME_BYTES; i += 2)
        begin
            if ($urandom_range(0, 99) < 40)
                fr[i] = {pick_stream(filt), 1'b1};
            else
                fr[i] = {7'($urandom), 1'b0};
            fr[i+1] = 8'($urandom);
        end
        for (i = 0; i < keep; i++)
        begin
            if (i % 2 == 0 && $urandom_range(0, 9) == 0)
                send_filler();
            send_byte(fr[i]);
        end
    endtask

    task automatic run_phase(input logic signed [7:0] filt, input int unsigned n);
        int unsigned stop;
        int unsigned r;
        stop = items_sent + n;
        send_sync();
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                send_frame(filt, FRAME_BYTES);
            else if (r < 75)
            begin
                send_frame(filt, $urandom_range(1, FRAME_BYTES - 1));
                send_sync();
            end
            else if (r < 85)
                send_sync();
            else if (r < 93)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            else
            begin
                // FF FF FF then a random byte: a near miss on the sync word unless it is 7F
                send_byte(HALF_LOW);
                send_byte(HALF_LOW);
                send_byte(HALF_LOW);
                send_byte(8'($urandom_range(0, 254)));
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_filter(input logic signed [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FILTER_ADDR;
        pwdata  <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.filter = v;
        filter_settings++;
    endtask

    // output side: random stalls plus one long hold-off
    initial
    begin
        int unsigned stall_left;
        int unsigned cycles;
        int unsigned results_seen;
        stall_left   = 0;
        cycles       = 0;
        results_seen = 0;
        out_ready   <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (out_valid && out_ready)
            begin
                sb.check_word(out_byte, stream_id, last);
                results_seen++;
            end
            if (cycles % 64 == 0)
                rx_stall_pct = pick_pct();
            if (!long_hold_done && results_seen >= 20)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 15) == 0)
                    stall_left = $urandom_range(10, 40);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_trace_formatter_frame_deframer_top: FAIL");
        $finish;
    end

    initial
    begin
        int i;
        sb              = new();
        items_sent      = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        filter_settings = 1;
        long_hold_done  = 1'b0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored before sync, then one hand-built frame with a filler pair
        send_byte(8'h00);
        send_byte(HALF_HIGH);
        send_sync();
        for (i = 0; i < FRAME_BYTES; i++)
        begin
            if (i == 4)
                send_filler();
            send_byte(DEMO_FRAME[127 - 8*i -: 8]);
        end
        run_phase(-8'sd1, 80);
        settle();

        write_filter(8'sd127);
        run_phase(8'sd127, 80);
        settle();

        write_filter(8'sd0);
        run_phase(8'sd0, 60);
        settle();

        write_filter(8'($urandom_range(1, 126)));
        run_phase(sb.filter, 90);
        settle();

        write_filter(-8'sd1);
        run_phase(-8'sd1, 90);
        settle();

        $display("covered %0d input words, %0d frames, %0d output words checked",
                 items_sent, sb.frames_done, sb.words_checked);
        $display("over %0d stream filter settings, long output hold-off %0s",
                 filter_settings, long_hold_done ? "applied" : "not reached");
        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("tb_trace_formatter_frame_deframer_top: PASS");
        else
            $display("tb_trace_formatter_frame_deframer_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tffd_pkg.sv
design/tffd_ctrl.sv
design/tffd_dp.sv
design/trace_formatter_frame_deframer_top.sv
design/tffd_checker.sv
bench/tb_trace_formatter_frame_deframer_top.sv
